@@ sv/write_protect_dirty_page_tracker_defines.svh @@
// ----------------------------------------------------------------------------
// Write-protect dirty page tracker: assertion macros
// Shared concurrent assertion forms, clocked and reset-qualified.
// ----------------------------------------------------------------------------
`ifndef WRITE_PROTECT_DIRTY_PAGE_TRACKER_DEFINES_SVH
`define WRITE_PROTECT_DIRTY_PAGE_TRACKER_DEFINES_SVH

// Same-cycle implication.
`define WPDP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define WPDP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/wpdp_pkg.sv @@
// ----------------------------------------------------------------------------
// wpdp_pkg
// Types, codes and helpers shared by the dirty page tracker modules.
// ----------------------------------------------------------------------------
package wpdp_pkg;

  localparam int unsigned NUM_PAGES_DEF  = 32768;
  localparam int unsigned PAGE_SHIFT_DEF = 12;
  localparam int unsigned FIFO_DEPTH_DEF = 2;

  // Page index width covering the largest supported page count.
  localparam int unsigned PG_MAX_W = 20;
  // Page index width on the result port.
  localparam int unsigned PAGE_OUT_W = 15;
  localparam int unsigned ADDR_W = 64;
  localparam int unsigned WORD_W = 64;

  typedef enum logic [1:0] {
    CMD_WRITE     = 2'd0,
    CMD_PROTECT   = 2'd1,
    CMD_UNPROTECT = 2'd2,
    CMD_CONSUME   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_PASS      = 3'd0,
    ST_DIRTIED   = 3'd1,
    ST_OUTSIDE   = 3'd2,
    ST_PROT_DONE = 3'd3,
    ST_FOUND     = 3'd4,
    ST_NONE      = 3'd5
  } status_e;

  // Classified operation handed from front to back.
  typedef enum logic [2:0] {
    OP_WRITE    = 3'd0,
    OP_OUTSIDE  = 3'd1,
    OP_PROT     = 3'd2,
    OP_UNPROT   = 3'd3,
    OP_PROT_NOP = 3'd4,
    OP_CONSUME  = 3'd5
  } op_e;

  typedef struct packed {
    op_e                 op;
    logic [PG_MAX_W-1:0] page;
  } work_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

  // Index of the lowest set bit; 0 for an empty word.
  function automatic logic [5:0] ffs64(input logic [WORD_W-1:0] v);
    logic [5:0] r;
    r = '0;
    for (int k = WORD_W - 1; k >= 0; k--) begin
      if (v[k]) r = 6'(k);
    end
    return r;
  endfunction

endpackage

@@ sv/write_protect_dirty_page_tracker.sv @@
// ----------------------------------------------------------------------------
// write_protect_dirty_page_tracker
// Per-page write-protect and dirty bitmaps with lowest-dirty-page consume.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel (cfg_valid_i/cfg_ready_o, cfg_ram_base_i) loads the RAM base;
//   write it while the block is idle. cfg_ready_o is always high.
//   in channel (in_valid_i/in_ready_o) takes one command word: write access,
//   protect, unprotect or consume. out channel (out_valid_o/out_ready_i)
//   returns exactly one status word per command, in order.
// Structure: the front subtracts the base and classifies in the accept cycle,
//   a short queue decouples it from the back, which does a read-modify-write
//   on the bitmap RAMs (registered read ports).
// Back flow: out-of-range writes or pages and consume with nothing dirty go
//   from S_IDLE to S_DONE; in-range writes and protect changes pass S_MOD;
//   consume passes S_C_L0 and S_C_UPD (summary flag encode, summary RAM read,
//   dirty RAM read). A word is taken from the queue only when the back is idle.
// Reset: a clearing pass zeroes every bitmap word (512 at 32768 pages);
//   in_ready_o stays low, config writes are taken.
// Stall: with out_ready_i low the finished word waits in the output register,
//   the back pauses, the queue fills (FIFO_DEPTH words), then in_ready_o drops.
// ----------------------------------------------------------------------------
module write_protect_dirty_page_tracker #(
  parameter int unsigned NUM_PAGES  = wpdp_pkg::NUM_PAGES_DEF,
  parameter int unsigned PAGE_SHIFT = wpdp_pkg::PAGE_SHIFT_DEF,
  parameter int unsigned FIFO_DEPTH = wpdp_pkg::FIFO_DEPTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [wpdp_pkg::ADDR_W-1:0]     cfg_ram_base_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [1:0]                      cmd_i,
  input  logic [wpdp_pkg::ADDR_W-1:0]     write_address_i,
  input  logic [14:0]                     page_number_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [2:0]                      status_o,
  output logic [wpdp_pkg::PAGE_OUT_W-1:0] page_found_o
);

  wpdp_pkg::back_stat_t back_stat;
  wpdp_pkg::work_t      push_data, head_data;
  logic                 push_valid, push_ready;
  logic                 head_valid, pop;

  // Front: base register, offset check, classification.
  wpdp_front #(
    .NUM_PAGES  (NUM_PAGES),
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_ram_base_i  (cfg_ram_base_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .cmd_i           (cmd_i),
    .write_address_i (write_address_i),
    .page_number_i   (page_number_i),
    .back_stat_i     (back_stat),
    .push_valid_o    (push_valid),
    .push_ready_i    (push_ready),
    .push_data_o     (push_data)
  );

  // Queue between classification and execution.
  wpdp_work_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .head_valid_o (head_valid),
    .head_data_o  (head_data),
    .pop_i        (pop)
  );

  // Back: bitmap RAMs, summary levels, result register.
  wpdp_back #(
    .NUM_PAGES (NUM_PAGES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_data_i  (head_data),
    .pop_o        (pop),
    .back_stat_o  (back_stat),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .page_found_o (page_found_o)
  );

endmodule

@@ sv/wpdp_front.sv @@
// ----------------------------------------------------------------------------
// wpdp_front
// Holds the RAM base, classifies incoming words and pushes them to the queue.
// ----------------------------------------------------------------------------
module wpdp_front #(
  parameter int unsigned NUM_PAGES  = wpdp_pkg::NUM_PAGES_DEF,
  parameter int unsigned PAGE_SHIFT = wpdp_pkg::PAGE_SHIFT_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [wpdp_pkg::ADDR_W-1:0] cfg_ram_base_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  cmd_i,
  input  logic [wpdp_pkg::ADDR_W-1:0] write_address_i,
  input  logic [14:0]                 page_number_i,
  input  wpdp_pkg::back_stat_t        back_stat_i,
  output logic                        push_valid_o,
  input  logic                        push_ready_i,
  output wpdp_pkg::work_t             push_data_o
);

  localparam logic [wpdp_pkg::ADDR_W-1:0] RAM_BYTES =
    wpdp_pkg::ADDR_W'(NUM_PAGES) << PAGE_SHIFT;

  logic [wpdp_pkg::ADDR_W-1:0] ram_base_q;
  logic [wpdp_pkg::ADDR_W-1:0] offset;
  wpdp_pkg::cmd_e              cmd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ram_base_q <= '0;
    end else if (cfg_valid_i) begin
      ram_base_q <= cfg_ram_base_i;
    end
  end

  assign cmd    = wpdp_pkg::cmd_e'(cmd_i);
  assign offset = write_address_i - ram_base_q;

  assign in_ready_o   = push_ready_i && !back_stat_i.clearing;
  assign push_valid_o = in_valid_i && in_ready_o;

  always_comb begin
    push_data_o.op   = wpdp_pkg::OP_CONSUME;
    push_data_o.page = '0;
    case (cmd)
      wpdp_pkg::CMD_WRITE: begin
        if (offset >= RAM_BYTES) begin
          push_data_o.op = wpdp_pkg::OP_OUTSIDE;
        end else begin
          push_data_o.op   = wpdp_pkg::OP_WRITE;
          push_data_o.page = wpdp_pkg::PG_MAX_W'(offset >> PAGE_SHIFT);
        end
      end
      wpdp_pkg::CMD_PROTECT, wpdp_pkg::CMD_UNPROTECT: begin
        push_data_o.page = wpdp_pkg::PG_MAX_W'(page_number_i);
        if (32'(page_number_i) >= 32'(NUM_PAGES)) begin
          push_data_o.op = wpdp_pkg::OP_PROT_NOP;
        end else if (cmd == wpdp_pkg::CMD_PROTECT) begin
          push_data_o.op = wpdp_pkg::OP_PROT;
        end else begin
          push_data_o.op = wpdp_pkg::OP_UNPROT;
        end
      end
      default: begin
        push_data_o.op = wpdp_pkg::OP_CONSUME;
      end
    endcase
  end

endmodule

@@ sv/wpdp_work_fifo.sv @@
// ----------------------------------------------------------------------------
// wpdp_work_fifo
// Short queue of classified words between front and back.
// ----------------------------------------------------------------------------
`include "write_protect_dirty_page_tracker_defines.svh"

module wpdp_work_fifo #(
  parameter int unsigned DEPTH = wpdp_pkg::FIFO_DEPTH_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  output logic            push_ready_o,
  input  wpdp_pkg::work_t push_data_i,
  output logic            head_valid_o,
  output wpdp_pkg::work_t head_data_o,
  input  logic            pop_i
);

  localparam int unsigned PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  wpdp_pkg::work_t  entry_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign push_ready_o = (cnt_q != CNT_W'(DEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_data_o  = entry_q[rd_ptr_q];
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  `WPDP_ASSERT_IMP(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= CNT_W'(DEPTH), "queue count past depth")
  `WPDP_ASSERT_NXT(a_cnt_grow, clk_i, rst_ni, do_push && !do_pop, cnt_q == $past(cnt_q) + 1'b1, "queue count did not grow on push")

endmodule

@@ sv/wpdp_back.sv @@
// ----------------------------------------------------------------------------
// wpdp_back
// Executes queued words against the protect and dirty bitmaps.
// ----------------------------------------------------------------------------
`include "write_protect_dirty_page_tracker_defines.svh"

module wpdp_back #(
  parameter int unsigned NUM_PAGES = wpdp_pkg::NUM_PAGES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              head_valid_i,
  input  wpdp_pkg::work_t                   head_data_i,
  output logic                              pop_o,
  output wpdp_pkg::back_stat_t              back_stat_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [2:0]                        status_o,
  output logic [wpdp_pkg::PAGE_OUT_W-1:0]   page_found_o
);

  localparam int unsigned PG_W    = (NUM_PAGES > 128) ? $clog2(NUM_PAGES) : 7;
  localparam int unsigned WIDX_W  = PG_W - 6;
  localparam int unsigned WORDS   = 2 ** WIDX_W;
  localparam int unsigned L1IDX_W = (WIDX_W > 7) ? WIDX_W - 6 : 1;
  localparam int unsigned L1WORDS = 2 ** L1IDX_W;
  localparam int unsigned W       = wpdp_pkg::WORD_W;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_MOD   = 7'b0000100,
    S_C_L0  = 7'b0001000,
    S_C_UPD = 7'b0010000,
    S_DONE  = 7'b0100000,
    S_SPARE = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // Bitmaps plus a per-word summary (level 1) and per-summary-word flags.
  logic [W-1:0] prot_mem  [WORDS];
  logic [W-1:0] dirty_mem [WORDS];
  logic [W-1:0] s1_mem    [L1WORDS];
  logic [L1WORDS-1:0] l2_q;

  logic [W-1:0] prot_rd_q, dirty_rd_q, s1_rd_q;
  logic [W-1:0] prot_wd, dirty_wd, s1_wd;
  logic         prot_we, dirty_we, s1_we;
  logic [WIDX_W-1:0]  waddr, raddr;
  logic [L1IDX_W-1:0] s1_waddr, s1_raddr;
  logic         l2_set, l2_clr;

  logic [WIDX_W-1:0]  clr_cnt_q;
  wpdp_pkg::op_e      op_q;
  logic [PG_W-1:0]    page_q;
  logic [L1IDX_W-1:0] l1_q, l1_d;
  logic [WIDX_W-1:0]  cw_q, cw_d;
  logic [W-1:0]       s1w_q;

  wpdp_pkg::status_e  res_status_q, res_status_d;
  logic [PG_W-1:0]    res_page_q, res_page_d;
  logic               res_en;

  logic               out_valid_q;
  wpdp_pkg::status_e  out_status_q;
  logic [wpdp_pkg::PAGE_OUT_W-1:0] out_page_q;
  logic               out_load;

  logic [PG_W-1:0]    head_page;
  logic [WIDX_W-1:0]  head_w, page_w;
  logic [W-1:0]       page_mask, new_dirty, new_s1;
  logic [5:0]         ffs_j, ffs_b;

  function automatic logic [L1IDX_W-1:0] ffs_l2(input logic [L1WORDS-1:0] v);
    logic [L1IDX_W-1:0] r;
    r = '0;
    for (int k = L1WORDS - 1; k >= 0; k--) begin
      if (v[k]) r = L1IDX_W'(k);
    end
    return r;
  endfunction

  assign head_page = PG_W'(head_data_i.page);
  assign head_w    = WIDX_W'(head_page >> 6);
  assign page_w    = WIDX_W'(page_q >> 6);
  assign page_mask = W'(1) << page_q[5:0];
  assign ffs_j     = wpdp_pkg::ffs64(s1_rd_q);
  assign ffs_b     = wpdp_pkg::ffs64(dirty_rd_q);
  assign new_dirty = dirty_rd_q & ~(W'(1) << ffs_b);
  assign new_s1    = s1w_q & ~(W'(1) << 6'(cw_q));

  assign back_stat_o.clearing = (state_q == S_CLEAR);

  always_comb begin
    state_d      = state_q;
    pop_o        = 1'b0;
    prot_we      = 1'b0;
    dirty_we     = 1'b0;
    s1_we        = 1'b0;
    prot_wd      = '0;
    dirty_wd     = '0;
    s1_wd        = '0;
    waddr        = page_w;
    s1_waddr     = l1_q;
    raddr        = head_w;
    s1_raddr     = L1IDX_W'(head_w >> 6);
    l1_d         = L1IDX_W'(head_w >> 6);
    cw_d         = WIDX_W'({l1_q, ffs_j});
    l2_set       = 1'b0;
    l2_clr       = 1'b0;
    res_en       = 1'b0;
    res_status_d = wpdp_pkg::ST_PASS;
    res_page_d   = '0;
    out_load     = 1'b0;
    case (state_q)
      S_CLEAR: begin
        prot_we  = 1'b1;
        dirty_we = 1'b1;
        s1_we    = 1'b1;
        waddr    = clr_cnt_q;
        s1_waddr = L1IDX_W'(clr_cnt_q);
        if (clr_cnt_q == '1) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (head_valid_i) begin
          pop_o = 1'b1;
          case (head_data_i.op)
            wpdp_pkg::OP_WRITE, wpdp_pkg::OP_PROT, wpdp_pkg::OP_UNPROT: begin
              state_d = S_MOD;
            end
            wpdp_pkg::OP_CONSUME: begin
              if (l2_q == '0) begin
                res_en       = 1'b1;
                res_status_d = wpdp_pkg::ST_NONE;
                state_d      = S_DONE;
              end else begin
                s1_raddr = ffs_l2(l2_q);
                l1_d     = ffs_l2(l2_q);
                state_d  = S_C_L0;
              end
            end
            wpdp_pkg::OP_OUTSIDE: begin
              res_en       = 1'b1;
              res_status_d = wpdp_pkg::ST_OUTSIDE;
              state_d      = S_DONE;
            end
            default: begin
              res_en       = 1'b1;
              res_status_d = wpdp_pkg::ST_PROT_DONE;
              state_d      = S_DONE;
            end
          endcase
        end
      end
      S_MOD: begin
        res_en  = 1'b1;
        state_d = S_DONE;
        if (op_q == wpdp_pkg::OP_WRITE) begin
          if ((prot_rd_q & page_mask) != '0) begin
            prot_we      = 1'b1;
            prot_wd      = prot_rd_q & ~page_mask;
            dirty_we     = 1'b1;
            dirty_wd     = dirty_rd_q | page_mask;
            s1_we        = 1'b1;
            s1_wd        = s1_rd_q | (W'(1) << 6'(page_w));
            l2_set       = 1'b1;
            res_status_d = wpdp_pkg::ST_DIRTIED;
            res_page_d   = page_q;
          end else begin
            res_status_d = wpdp_pkg::ST_PASS;
          end
        end else begin
          prot_we      = 1'b1;
          prot_wd      = (op_q == wpdp_pkg::OP_PROT) ? (prot_rd_q | page_mask)
                                                     : (prot_rd_q & ~page_mask);
          res_status_d = wpdp_pkg::ST_PROT_DONE;
        end
      end
      S_C_L0: begin
        raddr   = cw_d;
        state_d = S_C_UPD;
      end
      S_C_UPD: begin
        dirty_we = 1'b1;
        dirty_wd = new_dirty;
        waddr    = cw_q;
        if (new_dirty == '0) begin
          s1_we  = 1'b1;
          s1_wd  = new_s1;
          l2_clr = (new_s1 == '0);
        end
        res_en       = 1'b1;
        res_status_d = wpdp_pkg::ST_FOUND;
        res_page_d   = PG_W'({cw_q, ffs_b});
        state_d      = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      l2_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_cnt_q <= clr_cnt_q + 1'b1;
      if (l2_set) l2_q[l1_q] <= 1'b1;
      if (l2_clr) l2_q[l1_q] <= 1'b0;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      op_q   <= head_data_i.op;
      page_q <= head_page;
      l1_q   <= l1_d;
    end
    if (state_q == S_C_L0) begin
      cw_q  <= cw_d;
      s1w_q <= s1_rd_q;
    end
    if (res_en) begin
      res_status_q <= res_status_d;
      res_page_q   <= res_page_d;
    end
    if (out_load) begin
      out_status_q <= res_status_q;
      out_page_q   <= wpdp_pkg::PAGE_OUT_W'(res_page_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (prot_we) prot_mem[waddr] <= prot_wd;
    prot_rd_q <= prot_mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (dirty_we) dirty_mem[waddr] <= dirty_wd;
    dirty_rd_q <= dirty_mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (s1_we) s1_mem[s1_waddr] <= s1_wd;
    s1_rd_q <= s1_mem[s1_raddr];
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign page_found_o = out_page_q;

  `WPDP_ASSERT_IMP(a_s1_nonzero, clk_i, rst_ni, state_q == S_C_L0, s1_rd_q != '0, "summary word empty under set flag")
  `WPDP_ASSERT_IMP(a_dirty_nonzero, clk_i, rst_ni, state_q == S_C_UPD, dirty_rd_q != '0, "dirty word empty under set summary bit")

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// Dirty page tracker testbench
// Drives protect, unprotect, write and consume words through the tracker
// under four RAM base settings, predicts every status word from a local copy
// of both page bitmaps, and checks each returned word in order.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NUM_PAGES  = wpdp_pkg::NUM_PAGES_DEF;
  localparam int unsigned PAGE_SHIFT = wpdp_pkg::PAGE_SHIFT_DEF;
  localparam int unsigned MAP_WORDS  = (NUM_PAGES + 63) / 64;
  localparam logic [63:0] RAM_BYTES  = 64'(NUM_PAGES) << PAGE_SHIFT;
  localparam int unsigned IDLE_PCT   = 17;
  // Window of accepted words in which neither side idles.
  localparam int unsigned QUIET_FROM = 400;
  localparam int unsigned QUIET_TO   = 560;
  // Long receiver hold-off, started once this many words are in.
  localparam int unsigned HOLD_AT    = 700;
  localparam int unsigned HOLD_LEN   = 300;

  typedef struct packed {
    wpdp_pkg::cmd_e cmd;
    logic [63:0]    addr;
    logic [14:0]    page;
  } cmd_word_t;

  typedef struct packed {
    wpdp_pkg::status_e status;
    logic [14:0]       page;
  } track_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [63:0] cfg_ram_base_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  cmd_i = wpdp_pkg::CMD_WRITE;
  logic [63:0] write_address_i = '0;
  logic [14:0] page_number_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [2:0]  status_o;
  logic [14:0] page_found_o;

  write_protect_dirty_page_tracker u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_ram_base_i (cfg_ram_base_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .cmd_i          (cmd_i),
    .write_address_i(write_address_i),
    .page_number_i  (page_number_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .page_found_o   (page_found_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Words waiting to be offered, and status words owed by the block.
  cmd_word_t     cmd_words_q[$];
  track_result_t status_words_q[$];

  // Local copy of the tracker state.
  logic [63:0] ram_base_model;
  logic [63:0] dirty_map[MAP_WORDS];
  logic [63:0] protect_map[MAP_WORDS];

  int unsigned words_queued    = 0;
  int unsigned words_accepted  = 0;
  int unsigned results_checked = 0;
  int unsigned error_count     = 0;
  int unsigned hold_left       = 0;
  bit          hold_fired      = 1'b0;
  int unsigned status_seen[6];

  cmd_word_t     next_word;
  track_result_t owed_word;

  wire no_idle = (words_accepted >= QUIET_FROM) && (words_accepted < QUIET_TO);

  // --------------------------------------------------------------------------
  // Prediction: applies one command word to the local bitmaps and returns
  // the status word the block must produce for it.
  // --------------------------------------------------------------------------
  function automatic track_result_t tracker_predict(input cmd_word_t w);
    track_result_t r;
    logic [63:0]   off;
    int unsigned   pg;
    int unsigned   wi;
    int unsigned   bi;
    bit            hit;
    r.status = wpdp_pkg::ST_PASS;
    r.page   = '0;
    hit      = 1'b0;
    case (w.cmd)
      wpdp_pkg::CMD_WRITE: begin
        // Offset wraps modulo 2^64, so an address below the base lands
        // far above the RAM size.
        off = w.addr - ram_base_model;
        if (off >= RAM_BYTES) begin
          r.status = wpdp_pkg::ST_OUTSIDE;
        end else begin
          pg = 32'(off >> PAGE_SHIFT);
          wi = pg / 64;
          bi = pg % 64;
          if (protect_map[wi][bi]) begin
            dirty_map[wi][bi]   = 1'b1;
            protect_map[wi][bi] = 1'b0;
            r.status = wpdp_pkg::ST_DIRTIED;
            r.page   = 15'(pg);
          end
        end
      end
      wpdp_pkg::CMD_PROTECT, wpdp_pkg::CMD_UNPROTECT: begin
        // A page at or above the page count changes nothing; unreachable
        // through a 15-bit field at the default size, kept for generality.
        if (32'(w.page) < NUM_PAGES) begin
          wi = 32'(w.page) / 64;
          bi = 32'(w.page) % 64;
          protect_map[wi][bi] = (w.cmd == wpdp_pkg::CMD_PROTECT);
        end
        r.status = wpdp_pkg::ST_PROT_DONE;
      end
      default: begin
        // Lowest dirty page wins; none dirty gives page 0.
        r.status = wpdp_pkg::ST_NONE;
        for (int i = 0; i < MAP_WORDS; i++) begin
          if (!hit && dirty_map[i] != '0) begin
            for (int b = 63; b >= 0; b--) begin
              if (dirty_map[i][b]) bi = b;
            end
            dirty_map[i][bi] = 1'b0;
            r.status = wpdp_pkg::ST_FOUND;
            r.page   = 15'(i * 64 + bi);
            hit      = 1'b1;
          end
        end
      end
    endcase
    return r;
  endfunction

  task automatic flag_mismatch(input string what);
    error_count++;
    $display("mismatch at result %0d: %s", results_checked, what);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Mostly low pages (a few bitmap words) or the top pages, some anywhere.
  function automatic logic [14:0] pick_page();
    case ($urandom_range(3))
      0, 1:    return 15'($urandom_range(255));
      2:       return 15'(NUM_PAGES - 1 - $urandom_range(255));
      default: return 15'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] page_address(input logic [14:0] p);
    return ram_base_model + (64'(p) << PAGE_SHIFT) + 64'($urandom_range(4095));
  endfunction

  function automatic logic [63:0] outside_address();
    case ($urandom_range(3))
      0:       return ram_base_model - 64'(1 + $urandom_range(4095));
      1:       return ram_base_model + RAM_BYTES + 64'($urandom_range(4095));
      2:       return ram_base_model - 64'({$urandom, 1'b1});
      default: return rand64();
    endcase
  endfunction

  task automatic push_word(input wpdp_pkg::cmd_e c, input logic [63:0] a,
                           input logic [14:0] p);
    cmd_words_q.push_back(cmd_word_t'{cmd: c, addr: a, page: p});
    words_queued++;
  endtask

  // Fields a command does not use still carry random bits.
  task automatic push_write(input logic [63:0] a);
    push_word(wpdp_pkg::CMD_WRITE, a, 15'($urandom));
  endtask

  task automatic push_prot(input wpdp_pkg::cmd_e c, input logic [14:0] p);
    push_word(c, rand64(), p);
  endtask

  task automatic push_consume();
    push_word(wpdp_pkg::CMD_CONSUME, rand64(), 15'($urandom));
  endtask

  // Random mix: mostly protect-then-write sequences and consumes that walk
  // the dirty map, plus plain writes, out-of-range writes and noise.
  task automatic fill_random(input int unsigned n_words);
    int unsigned target;
    int unsigned roll;
    int unsigned k;
    logic [14:0] pg[4];
    target = words_queued + n_words;
    while (words_queued < target) begin
      roll = $urandom_range(99);
      if (roll < 30) begin
        k = $urandom_range(1, 4);
        for (int i = 0; i < k; i++) begin
          pg[i] = pick_page();
          push_prot(wpdp_pkg::CMD_PROTECT, pg[i]);
        end
        for (int i = 0; i < k; i++) push_write(page_address(pg[i]));
        if ($urandom_range(3) == 0) push_write(page_address(pg[0]));
      end else if (roll < 45) begin
        repeat ($urandom_range(1, 3)) push_consume();
      end else if (roll < 53) begin
        pg[0] = pick_page();
        push_prot(wpdp_pkg::CMD_PROTECT, pg[0]);
        push_prot(wpdp_pkg::CMD_UNPROTECT, pg[0]);
        push_write(page_address(pg[0]));
      end else if (roll < 68) begin
        push_write(page_address(pick_page()));
      end else if (roll < 80) begin
        push_write(outside_address());
      end else begin
        push_word(wpdp_pkg::cmd_e'($urandom_range(3)), rand64(), 15'($urandom));
      end
    end
  endtask

  // Config writes only while idle; the block is done once nothing is owed.
  task automatic load_ram_base(input logic [63:0] base);
    @(posedge clk_i);
    cfg_valid_i    <= 1'b1;
    cfg_ram_base_i <= base;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i    <= 1'b0;
    ram_base_model = base;
  endtask

  // Every queued word has come back as a checked result.
  task automatic wait_drained();
    while (results_checked != words_queued)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Driver: predicts each word at its accept edge, then offers the next one
  // or idles. valid and payload hold until accepted.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        status_words_q.push_back(tracker_predict(cmd_word_t'{
                                   cmd:  wpdp_pkg::cmd_e'(cmd_i),
                                   addr: write_address_i,
                                   page: page_number_i}));
        words_accepted <= words_accepted + 1;
      end
      if (!in_valid_i || in_ready_o) begin
        if (cmd_words_q.size() != 0 &&
            (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
          next_word = cmd_words_q.pop_front();
          in_valid_i      <= 1'b1;
          cmd_i           <= next_word.cmd;
          write_address_i <= next_word.addr;
          page_number_i   <= next_word.page;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each accepted status word against the oldest one owed.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_checked <= results_checked + 1;
        if (status_words_q.size() == 0) begin
          flag_mismatch($sformatf("status %0d page %0d with nothing owed",
                                  status_o, page_found_o));
        end else begin
          owed_word = status_words_q.pop_front();
          status_seen[int'(owed_word.status)]++;
          if (status_o !== owed_word.status)
            flag_mismatch($sformatf("status %0d, want %0d",
                                    status_o, owed_word.status));
          if (page_found_o !== owed_word.page)
            flag_mismatch($sformatf("page_found %0d, want %0d",
                                    page_found_o, owed_word.page));
        end
      end
      out_ready_i <= (hold_left == 0) && (no_idle || $urandom_range(99) >= IDLE_PCT);
    end
  end

  // One long output stall so the queue fills and in_ready_o drops.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left  <= 0;
      hold_fired <= 1'b0;
    end else if (!hold_fired && words_accepted >= HOLD_AT) begin
      hold_left  <= HOLD_LEN;
      hold_fired <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence: reset, then four base settings, each run until drained.
  // --------------------------------------------------------------------------
  initial begin
    foreach (dirty_map[i]) begin
      dirty_map[i]   = '0;
      protect_map[i] = '0;
    end
    ram_base_model = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Page-aligned base in the lower half of the address space.
    load_ram_base(64'h0000_7F3A_C000_0000);

    // Directed: empty consume, edges of RAM, protect/unprotect, dirty order.
    push_consume();
    push_write(ram_base_model);
    push_write(ram_base_model - 64'd1);
    push_write(ram_base_model + RAM_BYTES);
    push_write('1);
    push_write('0);
    push_prot(wpdp_pkg::CMD_PROTECT, 15'd0);
    push_prot(wpdp_pkg::CMD_PROTECT, 15'(NUM_PAGES - 1));
    push_prot(wpdp_pkg::CMD_PROTECT, 15'd100);
    push_prot(wpdp_pkg::CMD_PROTECT, 15'd101);
    push_prot(wpdp_pkg::CMD_PROTECT, 15'd200);
    push_prot(wpdp_pkg::CMD_UNPROTECT, 15'd200);
    push_write(ram_base_model + RAM_BYTES - 64'd1);
    push_write(ram_base_model);
    push_write(ram_base_model + (64'd101 << PAGE_SHIFT) + 64'hFFF);
    push_write(page_address(15'd100));
    push_write(page_address(15'd100));
    push_write(page_address(15'd200));
    repeat (5) push_consume();
    push_prot(wpdp_pkg::CMD_UNPROTECT, 15'(NUM_PAGES - 1));
    push_prot(wpdp_pkg::CMD_PROTECT, 15'd64);
    push_write(page_address(15'd64));
    push_consume();
    fill_random(280);
    wait_drained();

    load_ram_base('0);
    fill_random(280);
    wait_drained();

    // Top of the address space: page 0 starts at the very last address and wraps to address 0.
    load_ram_base('1);
    fill_random(280);
    wait_drained();

    // RAM straddles the 2^64 wrap.
    load_ram_base(64'hFFFF_FFFF_FC00_0000);
    fill_random(280);
    wait_drained();

    if (status_words_q.size() != 0)
      flag_mismatch($sformatf("%0d status words never returned",
                              status_words_q.size()));

    $display("run: %0d command words over four base settings, %0d results checked",
             words_accepted, results_checked);
    $display("statuses: pass %0d dirtied %0d outside %0d prot %0d found %0d none %0d",
             status_seen[wpdp_pkg::ST_PASS], status_seen[wpdp_pkg::ST_DIRTIED],
             status_seen[wpdp_pkg::ST_OUTSIDE], status_seen[wpdp_pkg::ST_PROT_DONE],
             status_seen[wpdp_pkg::ST_FOUND], status_seen[wpdp_pkg::ST_NONE]);
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest expected run.
  initial begin
    #2_000_000;
    $display("timeout after %0d words accepted", words_accepted);
    $display("testbench: done, errors");
    $finish;
  end

endmodule
